// ===== rtl/core/srtl_pkg.sv =====
package srtl_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 256;

  localparam int KEY_W     = 24;
  localparam int PORT_W    = 16;
  localparam int STATUS_W  = 3;
  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = 1;
  localparam int M_TDATA_W = 16;
  localparam int M_TUSER_W = 3;

  // operation codes carried on s_tuser
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_LOADED  = 3'd0,
    ST_FULL    = 3'd1,
    ST_MATCH   = 3'd2,
    ST_DEFAULT = 3'd3,
    ST_NONE    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    RES_LOADED,
    RES_FULL,
    RES_LOOKUP
  } res_kind_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic      capture;
    logic      probe_rd;
    logic      probe_upd;
    logic      pos_rd;
    logic      shift_init;
    logic      shift_step;
    logic      insert;
    logic      result_en;
    res_kind_t result_kind;
  } srtl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_lookup;
    logic full;
    logic lo_lt_hi;
    logic sh_gt_pos;
    logic wr_pending;
    logic out_free;
  } srtl_sts_t;

endpackage

// ===== rtl/core/srtl_dpath.sv =====
module srtl_dpath #(
  parameter int TABLE_DEPTH = srtl_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_op,
  input  logic [srtl_pkg::KEY_W-1:0]     in_key,
  input  logic [srtl_pkg::PORT_W-1:0]    in_port,
  input  srtl_pkg::srtl_cmd_t            cmd,
  output srtl_pkg::srtl_sts_t            sts,
  output logic                           m_valid,
  input  logic                           m_ready,
  output logic [srtl_pkg::STATUS_W-1:0]  m_status,
  output logic [srtl_pkg::PORT_W-1:0]    m_port
);
  import srtl_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [KEY_W-1:0]  key_mem  [TABLE_DEPTH];
  logic [PORT_W-1:0] port_mem [TABLE_DEPTH];

  logic              op_reg;
  logic [KEY_W-1:0]  key_reg;
  logic [PORT_W-1:0] port_reg;
  logic [CW-1:0]     lo;
  logic [CW-1:0]     hi;
  logic [CW-1:0]     sh;
  logic [IW-1:0]     wr_addr;
  logic              wr_pending;
  logic [CW-1:0]     count;
  logic              default_present;
  logic [PORT_W-1:0] default_port;
  logic [KEY_W-1:0]  rd_key;
  logic [PORT_W-1:0] rd_port;
  logic              out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [PORT_W-1:0] out_port;

  logic [CW-1:0]     mid;
  logic [CW-1:0]     sh_m1;
  logic              go_right;
  logic              sh_gt_pos;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic              wr_en;
  logic [IW-1:0]     wr_idx;
  logic [KEY_W-1:0]  wr_key;
  logic [PORT_W-1:0] wr_port;
  logic              pos_valid;
  logic [STATUS_W-1:0] lookup_status;
  logic [PORT_W-1:0] lookup_port;

  assign mid       = lo + ((hi - lo) >> 1);
  assign sh_m1     = sh - CW'(1);
  assign sh_gt_pos = (sh > lo);
  assign pos_valid = (lo < count);

  // loads go past equal keys, lookups stop at the leftmost equal key
  assign go_right = (op_reg == OP_LOOKUP) ? (rd_key < key_reg) : (rd_key <= key_reg);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = sh_m1[IW-1:0];
    if (cmd.probe_rd) begin
      rd_en   = 1'b1;
      rd_addr = mid[IW-1:0];
    end else if (cmd.pos_rd) begin
      rd_en   = 1'b1;
      rd_addr = lo[IW-1:0];
    end else if (cmd.shift_step && sh_gt_pos) begin
      rd_en   = 1'b1;
      rd_addr = sh_m1[IW-1:0];
    end
  end

  assign wr_en   = cmd.insert || (cmd.shift_step && wr_pending);
  assign wr_idx  = cmd.insert ? lo[IW-1:0] : wr_addr;
  assign wr_key  = cmd.insert ? key_reg : rd_key;
  assign wr_port = cmd.insert ? port_reg : rd_port;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_idx]  <= wr_key;
      port_mem[wr_idx] <= wr_port;
    end
    if (rd_en) begin
      rd_key  <= key_mem[rd_addr];
      rd_port <= port_mem[rd_addr];
    end
  end

  always_comb begin
    if (pos_valid && (rd_key == key_reg)) begin
      lookup_status = ST_MATCH;
      lookup_port   = rd_port;
    end else if (default_present) begin
      lookup_status = ST_DEFAULT;
      lookup_port   = default_port;
    end else begin
      lookup_status = ST_NONE;
      lookup_port   = '0;
    end
  end

  // payload, search, shift and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_reg   <= in_op;
      key_reg  <= in_key;
      port_reg <= in_port;
      lo       <= '0;
      hi       <= count;
    end
    if (cmd.probe_upd) begin
      if (go_right) begin
        lo <= mid + CW'(1);
      end else begin
        hi <= mid;
      end
    end
    if (cmd.shift_init) begin
      sh <= count;
    end
    if (cmd.shift_step && sh_gt_pos) begin
      sh      <= sh_m1;
      wr_addr <= sh[IW-1:0];
    end
    if (cmd.result_en) begin
      case (cmd.result_kind)
        RES_LOADED: begin
          out_status <= ST_LOADED;
          out_port   <= '0;
        end
        RES_FULL: begin
          out_status <= ST_FULL;
          out_port   <= '0;
        end
        RES_LOOKUP: begin
          out_status <= lookup_status;
          out_port   <= lookup_port;
        end
        default: begin
          out_status <= ST_NONE;
          out_port   <= '0;
        end
      endcase
    end
  end

  // table bookkeeping and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count           <= '0;
      default_present <= 1'b0;
      default_port    <= '0;
      wr_pending      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cmd.shift_init) begin
        wr_pending <= 1'b0;
      end else if (cmd.shift_step) begin
        wr_pending <= sh_gt_pos;
      end
      if (cmd.insert) begin
        count <= count + CW'(1);
        if ((key_reg == '0) && !default_present) begin
          default_present <= 1'b1;
          default_port    <= port_reg;
        end
      end
      if (cmd.result_en) begin
        out_valid <= 1'b1;
      end else if (m_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.is_lookup  = (op_reg == OP_LOOKUP);
    sts.full       = (count >= DEPTH_C);
    sts.lo_lt_hi   = (lo < hi);
    sts.sh_gt_pos  = sh_gt_pos;
    sts.wr_pending = wr_pending;
    sts.out_free   = !out_valid || m_ready;
  end

  assign m_valid  = out_valid;
  assign m_status = out_status;
  assign m_port   = out_port;

endmodule

// ===== rtl/core/srtl_ctrl.sv =====
module srtl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  srtl_pkg::srtl_sts_t  sts,
  output srtl_pkg::srtl_cmd_t  cmd
);
  import srtl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_COMPARE,
    S_SHIFT,
    S_INSERT,
    S_RESULT
  } state_t;

  state_t    state, state_next;
  res_kind_t res_kind, res_kind_next;

  always_comb begin
    cmd           = '0;
    state_next    = state;
    res_kind_next = res_kind;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (!sts.is_lookup && sts.full) begin
          res_kind_next = RES_FULL;
          state_next    = S_RESULT;
        end else if (sts.lo_lt_hi) begin
          cmd.probe_rd = 1'b1;
          state_next   = S_COMPARE;
        end else if (sts.is_lookup) begin
          cmd.pos_rd    = 1'b1;
          res_kind_next = RES_LOOKUP;
          state_next    = S_RESULT;
        end else begin
          cmd.shift_init = 1'b1;
          state_next     = S_SHIFT;
        end
      end
      S_COMPARE: begin
        cmd.probe_upd = 1'b1;
        state_next    = S_SEARCH;
      end
      S_SHIFT: begin
        if (sts.sh_gt_pos || sts.wr_pending) begin
          cmd.shift_step = 1'b1;
        end else begin
          state_next = S_INSERT;
        end
      end
      S_INSERT: begin
        cmd.insert    = 1'b1;
        res_kind_next = RES_LOADED;
        state_next    = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.result_en   = 1'b1;
          cmd.result_kind = res_kind;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      res_kind <= RES_LOADED;
    end else begin
      state    <= state_next;
      res_kind <= res_kind_next;
    end
  end

  assign s_tready = (state == S_IDLE);

endmodule

// ===== rtl/core/sorted_route_table_lookup_core.sv =====
// sorted /24 route table with binary-search lookup
// input channel s_*: one transfer per item; s_tuser selects load (0) or lookup (1),
//   s_tdata carries the 24-bit network key and the 16-bit port
// output channel m_*: one transfer per item; m_tuser is the status code
//   (loaded, table full, exact match, default route, no route), m_tdata the port
// loads keep the table in ascending key order; a key-0 load also sets the default
//   route the first time; a load into a full table is dropped with status full
// steps: a lookup runs P binary-search probes (P at most ceil(log2(n+1)) for n entries),
//   then reads the entry at the found position and registers its result; a load runs
//   the probes, moves the entries at and above its position up one place, inserts
//   and registers its result; a load into a full table skips the search
// each probe is a memory read followed by a compare, and each entry moved on insert
//   is read and then written one place up; the next transfer is taken from the
//   cycle after the result is registered
// one item is in flight at a time; s_tready is high only while the block is idle
// a finished result sits in the output register, so a new item is taken while the
//   receiver stalls; that item's result is held back until the register frees
// reset empties the table and clears the default route; the memory itself is not
//   cleared, only entries below the entry count are ever used
module sorted_route_table_lookup_core #(
  parameter int TABLE_DEPTH = srtl_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [srtl_pkg::S_TDATA_W-1:0]  s_tdata,  // network_key[23:0], port_number[39:24]
  input  logic [srtl_pkg::S_TUSER_W-1:0]  s_tuser,  // operation[0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [srtl_pkg::M_TDATA_W-1:0]  m_tdata,  // port_out[15:0]
  output logic [srtl_pkg::M_TUSER_W-1:0]  m_tuser   // status[2:0]
);
  import srtl_pkg::*;

  srtl_cmd_t cmd;
  srtl_sts_t sts;

  logic              in_op;
  logic [KEY_W-1:0]  in_key;
  logic [PORT_W-1:0] in_port;

  // unpack the input transfer
  assign in_op   = s_tuser[0];
  assign in_key  = s_tdata[KEY_W-1:0];
  assign in_port = s_tdata[KEY_W +: PORT_W];

  // sequencer: search, shift, insert and result steps
  srtl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table memory, search bounds, entry count and output register
  srtl_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .in_op    (in_op),
    .in_key   (in_key),
    .in_port  (in_port),
    .cmd      (cmd),
    .sts      (sts),
    .m_valid  (m_tvalid),
    .m_ready  (m_tready),
    .m_status (m_tuser),
    .m_port   (m_tdata)
  );

endmodule

// ===== rtl/core/srtl_checker.sv =====
module srtl_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [srtl_pkg::M_TDATA_W-1:0]  m_tdata,
  input logic [srtl_pkg::M_TUSER_W-1:0]  m_tuser
);
  import srtl_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // port is zero unless the status carries a route
  a_port_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_LOADED || m_tuser == ST_FULL || m_tuser == ST_NONE)
      |-> m_tdata == '0)
    else $error("nonzero port without a route");

  // one item at a time: ready drops after an input transfer
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while busy");

  // no result right out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a result cannot appear before the search and result states have run after its transfer
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !m_tvalid ##1 !m_tvalid)
    else $error("result too early");

endmodule

bind sorted_route_table_lookup_core srtl_checker u_srtl_checker (.*);
